// ===== sv/assert_macros.svh =====
// assertion helpers, included by alarm_table_match_and_next.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every rising edge outside reset
`define ATM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: check failed");

// implication checked on every rising edge outside reset
`define ATM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: check failed");

`else

`define ATM_ASSERT(lbl, clk, rstn, prop)
`define ATM_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/atm_pkg.sv =====
package atm_pkg;

  // stream widths, padded to whole bytes
  localparam int IN_W  = 48;
  localparam int OUT_W = 32;

  // operation codes carried on in_tuser
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_TICK    = 2'd2,
    OP_DISMISS = 2'd3
  } atm_op_t;

  // hour format codes, format 3 is taken as a plain 24-hour value
  localparam logic [1:0] FMT_H24 = 2'd0;
  localparam logic [1:0] FMT_AM  = 2'd1;
  localparam logic [1:0] FMT_PM  = 2'd2;
  localparam logic [1:0] FMT_RAW = 2'd3;

  localparam logic [4:0] HOUR_NOON = 5'd12;
  localparam logic [5:0] HOUR_HALF = 6'd12;

  // sort key weights
  localparam logic [19:0] KEY_MONTH = 20'd43200;
  localparam logic [19:0] KEY_DAY   = 20'd1440;
  localparam logic [19:0] KEY_HOUR  = 20'd60;

  // request that travels down the cell chain
  typedef struct packed {
    atm_op_t     op;
    logic [3:0]  idx;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [5:0]  set_hour;
    logic [5:0]  set_minute;
    logic [19:0] set_key;
    logic [3:0]  now_month;
    logic [4:0]  now_day;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
  } atm_req_t;

  // running result, msb first so it packs straight onto out_tdata
  typedef struct packed {
    logic        some_pending;
    logic [19:0] next_key;
    logic [3:0]  next_index;
    logic        next_valid;
    logic [3:0]  ring_index;
    logic        ring_valid;
  } atm_res_t;

  // am/pm hour to absolute hour, six bits wide so pm hours up to 43 fit
  function automatic logic [5:0] abs_hour(logic [4:0] h, logic [1:0] fmt);
    logic [5:0] hx;
    hx = {1'b0, h};
    if (fmt == FMT_PM && h != HOUR_NOON) return hx + HOUR_HALF;
    if (fmt == FMT_AM && h == HOUR_NOON) return '0;
    return hx;
  endfunction

endpackage

// ===== sv/atm_cell.sv =====
module atm_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  atm_pkg::atm_req_t in_req,
  input  atm_pkg::atm_res_t in_acc,
  output logic             out_vld,
  output atm_pkg::atm_req_t out_req,
  output atm_pkg::atm_res_t out_acc
);
  import atm_pkg::*;

  localparam logic [3:0] IDX4 = 4'(CELL_IDX);

  // stored alarm
  logic       valid_r, valid_nxt;
  logic       done_r, done_nxt;
  logic [3:0] month_r;
  logic [4:0] day_r;
  logic [5:0] hour_r;
  logic [5:0] minute_r;
  logic [19:0] key_r;

  logic       vld_r;
  atm_req_t   req_r;
  atm_res_t   acc_r, acc_nxt;

  logic       hit;
  logic       wr_load;
  logic       pend;
  logic       same;
  logic       later;

  assign hit     = (32'(in_req.idx) == CELL_IDX);
  assign wr_load = in_vld && in_req.op == OP_LOAD && hit;

  // table update for the passing request
  always_comb begin
    valid_nxt = valid_r;
    done_nxt  = done_r;
    if (in_vld) begin
      unique case (in_req.op)
        OP_CLEAR: begin
          valid_nxt = 1'b0;
          done_nxt  = 1'b0;
        end
        OP_LOAD: begin
          if (hit) begin
            valid_nxt = 1'b1;
            done_nxt  = 1'b0;
          end
        end
        OP_DISMISS: begin
          if (hit) done_nxt = 1'b1;
        end
        OP_TICK: begin
        end
        default: begin
        end
      endcase
    end
  end

  // compare against current time, lexicographic on the fields
  assign pend  = valid_nxt && !done_nxt;
  assign same  = {month_r, day_r, hour_r, minute_r} ==
                 {in_req.now_month, in_req.now_day, 1'b0, in_req.now_hour, in_req.now_minute};
  assign later = {month_r, day_r, hour_r, minute_r} >
                 {in_req.now_month, in_req.now_day, 1'b0, in_req.now_hour, in_req.now_minute};

  // fold this slot into the running result
  always_comb begin
    acc_nxt = in_acc;
    if (pend) acc_nxt.some_pending = 1'b1;
    if (pend && in_req.op == OP_TICK) begin
      if (!in_acc.ring_valid && same) begin
        acc_nxt.ring_valid = 1'b1;
        acc_nxt.ring_index = IDX4;
      end
      if (later && (!in_acc.next_valid || key_r < in_acc.next_key)) begin
        acc_nxt.next_valid = 1'b1;
        acc_nxt.next_index = IDX4;
        acc_nxt.next_key   = key_r;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
      vld_r   <= in_vld;
    end
  end

  // alarm fields and hand-off registers
  always_ff @(posedge clk) begin
    if (wr_load) begin
      month_r  <= in_req.set_month;
      day_r    <= in_req.set_day;
      hour_r   <= in_req.set_hour;
      minute_r <= in_req.set_minute;
      key_r    <= in_req.set_key;
    end
    if (in_vld) begin
      req_r <= in_req;
      acc_r <= acc_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_req = req_r;
  assign out_acc = acc_r;

endmodule

// ===== sv/alarm_table_match_and_next.sv =====
// Alarm table with one cell per slot. Each request (clear, load, dismiss or tick)
// is taken with its hour made absolute on entry, gets its sort key computed in the
// next cycle, then walks down the row of ALARM_SLOTS cells, one cell per
// cycle; each cell applies the operation to its own slot and folds its alarm into
// the running ring/next result. One request is in flight at a time: the next
// request can be taken in the cycle after the result leaves, not before. Every
// request returns exactly one result. in_tuser carries the opcode.
`include "assert_macros.svh"

module alarm_table_match_and_next #(
  parameter int ALARM_SLOTS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // entry_index, set_month, set_day, set_hour, set_minute, hour_format,
  // now_month, now_day, now_hour, now_minute
  input  logic [atm_pkg::IN_W-1:0] in_tdata,
  // opcode
  input  logic [1:0]               in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // ring_valid, ring_index, next_valid, next_index, next_key, some_pending
  output logic [atm_pkg::OUT_W-1:0] out_tdata
);
  import atm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_RUN,
    S_HOLD
  } state_t;

  state_t   state_r;
  logic     head_vld_r;
  logic     out_vld_r;
  atm_req_t req_r;
  atm_req_t req_in;
  atm_res_t res_r;
  logic [19:0] key_calc;
  logic     in_acc;

  logic [ALARM_SLOTS:0] vld;
  atm_req_t req_c [ALARM_SLOTS+1];
  atm_res_t acc_c [ALARM_SLOTS+1];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // unpack the request, hour made absolute on entry
  always_comb begin
    req_in            = '0;
    req_in.op         = atm_op_t'(in_tuser);
    req_in.idx        = in_tdata[3:0];
    req_in.set_month  = in_tdata[7:4];
    req_in.set_day    = in_tdata[12:8];
    req_in.set_hour   = abs_hour(in_tdata[17:13], in_tdata[25:24]);
    req_in.set_minute = in_tdata[23:18];
    req_in.now_month  = in_tdata[29:26];
    req_in.now_day    = in_tdata[34:30];
    req_in.now_hour   = in_tdata[39:35];
    req_in.now_minute = in_tdata[45:40];
  end

  // sort key of the alarm being loaded
  assign key_calc = 20'(req_r.set_month) * KEY_MONTH + 20'(req_r.set_day) * KEY_DAY +
                    20'(req_r.set_hour) * KEY_HOUR + 20'(req_r.set_minute);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      head_vld_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) state_r <= S_PREP;
        end
        S_PREP: begin
          head_vld_r <= 1'b1;
          state_r    <= S_RUN;
        end
        S_RUN: begin
          if (vld[ALARM_SLOTS]) begin
            out_vld_r <= 1'b1;
            state_r   <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_tready) begin
            out_vld_r <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= req_in;
    end else if (state_r == S_PREP) begin
      req_r.set_key <= key_calc;
    end
    if (state_r == S_RUN && vld[ALARM_SLOTS]) res_r <= acc_c[ALARM_SLOTS];
  end

  // row of slot cells
  assign vld[0]   = head_vld_r;
  assign req_c[0] = req_r;
  assign acc_c[0] = '0;

  for (genvar g = 0; g < ALARM_SLOTS; g++) begin : g_cell
    atm_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_vld (vld[g]),
      .in_req (req_c[g]),
      .in_acc (acc_c[g]),
      .out_vld(vld[g+1]),
      .out_req(req_c[g+1]),
      .out_acc(acc_c[g+1])
    );
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, res_r};

  // checks
  `ATM_ASSERT(a_one_in_flight, clk, rst_n, $onehot0(vld))
  `ATM_ASSERT_IMP(a_head_pulse, clk, rst_n, head_vld_r, state_r == S_RUN)
  `ATM_ASSERT_IMP(a_accept_empty, clk, rst_n, in_acc, vld == '0 && !out_vld_r)
  `ATM_ASSERT_IMP(a_tail_in_run, clk, rst_n, vld[ALARM_SLOTS], state_r == S_RUN)

endmodule

// ===== tb/alarm_table_checker.sv =====
`timescale 1ns / 1ps

module alarm_table_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  // entry_index, set_month, set_day, set_hour, set_minute, hour_format,
  // now_month, now_day, now_hour, now_minute
  input  logic [atm_pkg::IN_W-1:0]  in_tdata,
  // opcode
  input  logic [1:0]                in_tuser,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  // ring_valid, ring_index, next_valid, next_index, next_key, some_pending
  input  logic [atm_pkg::OUT_W-1:0] out_tdata,
  output int                        mismatch_count,
  output int                        awaited_count,
  output int                        result_count,
  output int                        ring_count,
  output int                        next_count
);
  import atm_pkg::*;

  localparam int SLOTS = 16;

  // request fields as they sit on in_tdata, msb first
  typedef struct packed {
    logic [1:0] pad;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [4:0] now_day;
    logic [3:0] now_month;
    logic [1:0] fmt;
    logic [5:0] set_minute;
    logic [4:0] set_hour;
    logic [4:0] set_day;
    logic [3:0] set_month;
    logic [3:0] idx;
  } alarm_req_t;

  // shadow alarm table
  logic [3:0] slot_month  [SLOTS];
  logic [4:0] slot_day    [SLOTS];
  logic [5:0] slot_hour   [SLOTS];
  logic [5:0] slot_minute [SLOTS];
  logic       slot_armed  [SLOTS];
  logic       slot_done   [SLOTS];

  atm_res_t awaited_q[$];
  atm_res_t want_res;
  atm_res_t got_res;

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
    result_count   = 0;
    ring_count     = 0;
    next_count     = 0;
  end

  // 12-hour clock to 24-hour, six bits wide so pm hours up to 43 fit
  function automatic logic [5:0] hour_24(logic [4:0] h, logic [1:0] fmt);
    logic [5:0] wide;
    wide = {1'b0, h};
    if (fmt == FMT_PM && h != HOUR_NOON) return wide + HOUR_HALF;
    if (fmt == FMT_AM && h == HOUR_NOON) return 6'd0;
    return wide;
  endfunction

  // field-by-field ordering, not a key compare
  function automatic bit is_later(int i, alarm_req_t rq);
    if (slot_month[i] != rq.now_month) return slot_month[i] > rq.now_month;
    if (slot_day[i] != rq.now_day) return slot_day[i] > rq.now_day;
    if (slot_hour[i] != {1'b0, rq.now_hour}) return slot_hour[i] > {1'b0, rq.now_hour};
    return slot_minute[i] > rq.now_minute;
  endfunction

  // apply one request to the table and work out its result
  function automatic atm_res_t predict_alarm_result(atm_op_t op, alarm_req_t rq);
    atm_res_t res;
    logic [19:0] key;
    res = '0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          slot_armed[i] = 1'b0;
          slot_done[i]  = 1'b0;
        end
      end
      OP_LOAD: begin
        slot_month[rq.idx]  = rq.set_month;
        slot_day[rq.idx]    = rq.set_day;
        slot_hour[rq.idx]   = hour_24(rq.set_hour, rq.fmt);
        slot_minute[rq.idx] = rq.set_minute;
        slot_armed[rq.idx]  = 1'b1;
        slot_done[rq.idx]   = 1'b0;
      end
      OP_DISMISS: begin
        slot_done[rq.idx] = 1'b1;
      end
      default: ;
    endcase
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_armed[i] || slot_done[i]) continue;
      res.some_pending = 1'b1;
      if (op != OP_TICK) continue;
      // exact time match, lowest slot wins
      if (!res.ring_valid && slot_month[i] == rq.now_month && slot_day[i] == rq.now_day &&
          slot_hour[i] == {1'b0, rq.now_hour} && slot_minute[i] == rq.now_minute) begin
        res.ring_valid = 1'b1;
        res.ring_index = 4'(i);
      end
      if (!is_later(i, rq)) continue;
      // earliest future alarm, ties to the lowest slot
      key = 20'(int'(slot_month[i]) * 43200 + int'(slot_day[i]) * 1440 +
                int'(slot_hour[i]) * 60 + int'(slot_minute[i]));
      if (!res.next_valid || key < res.next_key) begin
        res.next_valid = 1'b1;
        res.next_index = 4'(i);
        res.next_key   = key;
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // compare each result, then queue the prediction for a new request
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_armed[i] = 1'b0;
        slot_done[i]  = 1'b0;
      end
      awaited_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        result_count++;
        got_res = atm_res_t'(out_tdata[$bits(atm_res_t)-1:0]);
        if (awaited_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        end else begin
          want_res = awaited_q.pop_front();
          check_field("ring_valid", want_res.ring_valid, got_res.ring_valid);
          check_field("ring_index", want_res.ring_index, got_res.ring_index);
          check_field("next_valid", want_res.next_valid, got_res.next_valid);
          check_field("next_index", want_res.next_index, got_res.next_index);
          check_field("next_key", want_res.next_key, got_res.next_key);
          check_field("some_pending", want_res.some_pending, got_res.some_pending);
          check_field("padding", 0, out_tdata[atm_pkg::OUT_W-1:$bits(atm_res_t)]);
        end
      end
      if (in_tvalid && in_tready) begin
        want_res = predict_alarm_result(atm_op_t'(in_tuser), alarm_req_t'(in_tdata));
        if (want_res.ring_valid) ring_count++;
        if (want_res.next_valid) next_count++;
        awaited_q = {awaited_q, want_res};
      end
    end
    awaited_count = awaited_q.size();
  end

endmodule

// ===== tb/alarm_table_match_and_next_tb.sv =====
`timescale 1ns / 1ps

module alarm_table_match_and_next_tb;
  import atm_pkg::*;

  localparam int RANDOM_REQS = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic [1:0]           in_tuser = OP_CLEAR;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;

  int mismatch_count;
  int awaited_count;
  int result_count;
  int ring_count;
  int next_count;

  int  op_count[4];
  bit  quiet_in;

  // times of randomly loaded slots, used to aim ticks at them
  logic [3:0] aim_month  [16];
  logic [4:0] aim_day    [16];
  logic [4:0] aim_hour   [16];
  logic [5:0] aim_minute [16];
  bit         aim_known  [16];

  always #2 clk = ~clk;

  alarm_table_match_and_next u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  alarm_table_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count),
    .result_count   (result_count),
    .ring_count     (ring_count),
    .next_count     (next_count)
  );

  // mostly short gaps, a few long enough to span a whole request
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 24);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [IN_W-1:0] pack_request(
    logic [3:0] idx, logic [3:0] smo, logic [4:0] sd, logic [4:0] sh, logic [5:0] smi,
    logic [1:0] fmt, logic [3:0] nmo, logic [4:0] nd, logic [4:0] nh, logic [5:0] nmi);
    return {2'b00, nmi, nh, nd, nmo, fmt, smi, sh, sd, smo, idx};
  endfunction

  function automatic int pick_known_slot();
    int start;
    start = $urandom_range(0, 15);
    for (int k = 0; k < 16; k++) begin
      if (aim_known[(start + k) % 16]) return (start + k) % 16;
    end
    return -1;
  endfunction

  // present one request and hold it until accepted
  task automatic drive_request(atm_op_t op, logic [IN_W-1:0] data);
    int gap;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    op_count[op]++;
  endtask

  task automatic load_alarm(logic [3:0] idx, logic [3:0] mo, logic [4:0] d, logic [4:0] h,
                            logic [5:0] mi, logic [1:0] fmt);
    drive_request(OP_LOAD, pack_request(idx, mo, d, h, mi, fmt, 4'($urandom),
                                        5'($urandom), 5'($urandom), 6'($urandom)));
  endtask

  task automatic tick_at(logic [3:0] mo, logic [4:0] d, logic [4:0] h, logic [5:0] mi);
    drive_request(OP_TICK, pack_request(4'($urandom), 4'($urandom), 5'($urandom),
                                        5'($urandom), 6'($urandom), 2'($urandom),
                                        mo, d, h, mi));
  endtask

  task automatic table_op(atm_op_t op, logic [3:0] idx);
    drive_request(op, pack_request(idx, 4'($urandom), 5'($urandom), 5'($urandom),
                                   6'($urandom), 2'($urandom), 4'($urandom),
                                   5'($urandom), 5'($urandom), 6'($urandom)));
  endtask

  // load with a chosen 24-hour time, written in a random hour format, or random noise
  task automatic random_load();
    logic [3:0] idx;
    logic [3:0] mo;
    logic [4:0] d;
    logic [4:0] ah;
    logic [4:0] h;
    logic [5:0] mi;
    logic [1:0] fmt;
    int src;
    idx = 4'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      // noise: any bit pattern, including out of range fields and format 3
      load_alarm(idx, 4'($urandom), 5'($urandom), 5'($urandom), 6'($urandom),
                 2'($urandom));
      aim_known[idx] = 1'b0;
    end else begin
      src = pick_known_slot();
      if (src >= 0 && $urandom_range(0, 7) == 0) begin
        // same time as another slot, for ties
        mo = aim_month[src];
        d  = aim_day[src];
        ah = aim_hour[src];
        mi = aim_minute[src];
      end else begin
        mo = 4'($urandom_range(1, 12));
        d  = 5'($urandom_range(1, 31));
        ah = 5'($urandom_range(0, 23));
        mi = 6'($urandom_range(0, 59));
      end
      case ($urandom_range(0, 3))
        0: begin
          fmt = FMT_H24;
          h   = ah;
        end
        1: begin
          fmt = FMT_RAW;
          h   = ah;
        end
        default: begin
          if (ah < 5'd12) begin
            fmt = FMT_AM;
            h   = (ah == 5'd0 && $urandom_range(0, 1)) ? HOUR_NOON : ah;
          end else if (ah == 5'd12) begin
            fmt = FMT_PM;
            h   = $urandom_range(0, 1) ? HOUR_NOON : 5'd0;
          end else begin
            fmt = FMT_PM;
            h   = ah - 5'd12;
          end
        end
      endcase
      load_alarm(idx, mo, d, h, mi, fmt);
      aim_month[idx]  = mo;
      aim_day[idx]    = d;
      aim_hour[idx]   = ah;
      aim_minute[idx] = mi;
      aim_known[idx]  = 1'b1;
    end
  endtask

  // ticks mostly at or near a loaded time
  task automatic random_tick();
    int s;
    int r;
    s = pick_known_slot();
    r = $urandom_range(0, 99);
    if (s >= 0 && r < 35) begin
      tick_at(aim_month[s], aim_day[s], aim_hour[s], aim_minute[s]);
    end else if (s >= 0 && r < 65) begin
      tick_at(aim_month[s], aim_day[s], aim_hour[s] + 5'($urandom_range(0, 2)) - 5'd1,
              aim_minute[s] + 6'($urandom_range(0, 4)) - 6'd2);
    end else if (r < 75) begin
      tick_at(4'($urandom), 5'($urandom), 5'($urandom), 6'($urandom));
    end else begin
      tick_at(4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
              5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
    end
  endtask

  task automatic random_dismiss();
    int s;
    s = pick_known_slot();
    if (s >= 0 && $urandom_range(0, 9) < 7) table_op(OP_DISMISS, 4'(s));
    else table_op(OP_DISMISS, 4'($urandom));
  endtask

  // result side backpressure, with quiet stretches
  initial begin
    int stall_left;
    int cyc;
    stall_left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if ((cyc % 2000) >= 400 && $urandom_range(0, 9) < 3) stall_left = pick_gap(1'b0);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int r;
    quiet_in = 1'b0;
    for (int i = 0; i < 16; i++) aim_known[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, dismiss of an unloaded slot, then reload clears done
    tick_at(4'd1, 5'd1, 5'd0, 6'd0);
    table_op(OP_DISMISS, 4'd3);
    load_alarm(4'd3, 4'd1, 5'd1, 5'd7, 6'd0, FMT_H24);
    // 12 am is midnight, 12 pm stays noon, 11 pm is 23
    load_alarm(4'd0, 4'd12, 5'd31, HOUR_NOON, 6'd59, FMT_AM);
    load_alarm(4'd1, 4'd12, 5'd31, HOUR_NOON, 6'd59, FMT_PM);
    load_alarm(4'd2, 4'd6, 5'd15, 5'd11, 6'd30, FMT_PM);
    // field extremes, pm pushes the hour past 31
    load_alarm(4'd15, 4'd15, 5'd31, 5'd31, 6'd63, FMT_PM);
    load_alarm(4'd4, 4'd0, 5'd0, 5'd0, 6'd0, FMT_RAW);
    // equal keys from different fields
    load_alarm(4'd5, 4'd2, 5'd0, 5'd0, 6'd0, FMT_H24);
    load_alarm(4'd6, 4'd1, 5'd30, 5'd0, 6'd0, FMT_H24);
    // larger key but earlier day: not a future alarm
    load_alarm(4'd7, 4'd1, 5'd1, 5'd18, 6'd0, FMT_PM);
    load_alarm(4'd8, 4'd6, 5'd15, 5'd23, 6'd30, FMT_H24);
    tick_at(4'd1, 5'd2, 5'd0, 6'd0);
    tick_at(4'd6, 5'd15, 5'd23, 6'd30);
    table_op(OP_DISMISS, 4'd2);
    tick_at(4'd6, 5'd15, 5'd23, 6'd30);
    tick_at(4'd15, 5'd31, 5'd31, 6'd63);
    tick_at(4'd0, 5'd0, 5'd0, 6'd0);
    table_op(OP_DISMISS, 4'd15);
    // clear keeps times but drops every alarm
    table_op(OP_CLEAR, 4'd0);
    tick_at(4'd6, 5'd15, 5'd23, 6'd30);
    load_alarm(4'd9, 4'd3, 5'd3, 5'd3, 6'd3, FMT_AM);
    tick_at(4'd3, 5'd3, 5'd3, 6'd3);
    table_op(OP_DISMISS, 4'd9);
    tick_at(4'd3, 5'd3, 5'd3, 6'd3);

    // random traffic
    for (int n = 0; n < RANDOM_REQS; n++) begin
      quiet_in = (n % 300) < 60;
      r = $urandom_range(0, 99);
      if (r < 2) table_op(OP_CLEAR, 4'($urandom));
      else if (r < 37) random_load();
      else if (r < 85) random_tick();
      else random_dismiss();
    end
    in_tvalid = 1'b0;

    while (awaited_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d requests: %0d clear, %0d load, %0d tick, %0d dismiss; %0d results",
             op_count[OP_CLEAR] + op_count[OP_LOAD] + op_count[OP_TICK] +
             op_count[OP_DISMISS], op_count[OP_CLEAR], op_count[OP_LOAD],
             op_count[OP_TICK], op_count[OP_DISMISS], result_count);
    $display("Ticks that rang an alarm: %0d, ticks with a later alarm: %0d",
             ring_count, next_count);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== alarm_table_match_and_next.f =====
+incdir+sv
sv/atm_pkg.sv
sv/atm_cell.sv
sv/alarm_table_match_and_next.sv
tb/alarm_table_checker.sv
tb/alarm_table_match_and_next_tb.sv
